// ----- rtl/integer_text_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Integer text parser: assertion macros
// Shared property forms for the checker of the integer text parser.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_DEFINES_SVH
`define INTEGER_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define ITP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer_text_parser: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define ITP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer_text_parser: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define ITP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("integer_text_parser: reset check failed");

`endif

// ----- rtl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer text parser package
// Types, character codes and character decode functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

  localparam int MAX_CHARS = 4096;
  // Position counter saturates one above MAX_CHARS.
  localparam int POS_W = $clog2(MAX_CHARS + 2);
  localparam int OFF_W = 13;
  localparam int VAL_W = 64;
  localparam int BASE_W = 6;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CASE_BIT = 8'd32;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  typedef struct packed {
    logic              start_req;
    logic [BASE_W-1:0] base;
    logic [7:0]        ch;
  } itp_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] end_offset;
    logic             any_digits;
    logic             negative;
    logic [VAL_W-1:0] value;
  } itp_result_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } itp_digit_t;

  function automatic itp_digit_t digit_of(input logic [7:0] c);
    itp_digit_t d;
    logic [7:0] l;
    l = c | CASE_BIT;
    d.ok = 1'b0;
    d.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok = 1'b1;
      d.val = BASE_W'(c - CH_ZERO);
    end else if (l >= CH_LA && l <= CH_LZ) begin
      d.ok = 1'b1;
      d.val = BASE_W'(l - CH_LA + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_VT || c == CH_FF;
  endfunction

endpackage

// ----- rtl/itp_in_reg.sv -----
// ----------------------------------------------------------------------------
// Integer text parser input register
// Holds one character request until the parse stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itp_pkg::itp_item_t in_item,
  output logic              item_valid,
  input  logic              item_take,
  output itp_pkg::itp_item_t item
);
  import itp_pkg::*;

  logic take_now;

  assign take_now = item_valid && item_take;
  assign in_ready = !item_valid || take_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- rtl/itp_core.sv -----
// ----------------------------------------------------------------------------
// Integer text parser core
// Parse state, accumulator and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_take,
  input  itp_pkg::itp_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output itp_pkg::itp_result_t result
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    PH_DONE, PH_SPACE, PH_PREFIX, PH_ZERO, PH_ZEROX, PH_DIGITS
  } phase_t;

  phase_t            phase, phase_next;
  logic [BASE_W-1:0] active_base, active_base_next;
  logic [VAL_W-1:0]  accumulator, accumulator_next;
  logic              minus_seen, minus_seen_next;
  logic              digit_seen, digit_seen_next;
  logic [POS_W-1:0]  position, position_next;
  logic              emit;
  itp_result_t       result_next;

  // The parse stage moves whenever the result slot is free or draining.
  assign item_take = !res_valid || res_ready;

  always_comb begin
    logic              go_on;
    logic              adv;
    logic [POS_W-1:0]  pos_base;
    logic [POS_W-1:0]  endp;
    logic [BASE_W-1:0] ab;
    logic [VAL_W-1:0]  acc;
    logic              mns;
    logic              dsn;
    phase_t            ph;
    itp_digit_t        dig;

    dig = digit_of(item.ch);
    if (item.start_req) begin
      ph = PH_SPACE;
      ab = item.base;
      acc = '0;
      mns = 1'b0;
      dsn = 1'b0;
      pos_base = '0;
    end else begin
      ph = phase;
      ab = active_base;
      acc = accumulator;
      mns = minus_seen;
      dsn = digit_seen;
      pos_base = position;
    end
    go_on = 1'b1;
    adv = 1'b0;
    emit = 1'b0;
    endp = pos_base;

    if (ph == PH_DONE) begin
      go_on = 1'b0;
    end else if (ph == PH_ZEROX) begin
      go_on = 1'b0;
      if (dig.ok && dig.val < BASE_HEX) begin
        ab = BASE_HEX;
        acc = VAL_W'(dig.val);
        ph = PH_DIGITS;
        adv = 1'b1;
      end else begin
        // The parse ends just after the '0' that stood before the 'x'.
        endp = pos_base - POS_W'(1);
        emit = 1'b1;
        ph = PH_DONE;
      end
    end

    if (go_on && ph == PH_SPACE) begin
      if (is_space(item.ch)) begin
        adv = 1'b1;
        go_on = 1'b0;
      end else begin
        ph = PH_PREFIX;
        if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
          mns = (item.ch == CH_MINUS);
          adv = 1'b1;
          go_on = 1'b0;
        end
      end
    end

    if (go_on && ph == PH_PREFIX) begin
      if (item.ch == CH_ZERO && (ab == BASE_AUTO || ab == BASE_HEX)) begin
        acc = '0;
        dsn = 1'b1;
        ph = PH_ZERO;
        adv = 1'b1;
        go_on = 1'b0;
      end else begin
        if (ab == BASE_AUTO) ab = BASE_DEC;
        ph = PH_DIGITS;
      end
    end

    if (go_on && ph == PH_ZERO) begin
      if (item.ch == CH_LX || item.ch == CH_UX) begin
        ph = PH_ZEROX;
        adv = 1'b1;
        go_on = 1'b0;
      end else begin
        if (ab == BASE_AUTO) ab = BASE_OCT;
        ph = PH_DIGITS;
      end
    end

    if (go_on) begin
      if (ab >= BASE_MIN && ab <= BASE_MAX && dig.ok && dig.val < ab) begin
        acc = acc * VAL_W'(ab) + VAL_W'(dig.val);
        dsn = 1'b1;
        adv = 1'b1;
      end else begin
        emit = 1'b1;
        ph = PH_DONE;
      end
    end

    phase_next = ph;
    active_base_next = ab;
    accumulator_next = acc;
    minus_seen_next = mns;
    digit_seen_next = dsn;
    if (adv && pos_base < POS_W'(MAX_CHARS + 1)) begin
      position_next = pos_base + POS_W'(1);
    end else begin
      position_next = pos_base;
    end

    if (!dsn) begin
      endp = '0;
    end else if (endp > POS_W'(MAX_CHARS)) begin
      endp = POS_W'(MAX_CHARS);
    end
    result_next.value = mns ? (VAL_W'(0) - acc) : acc;
    result_next.negative = mns;
    result_next.any_digits = dsn;
    result_next.end_offset = OFF_W'(endp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DONE;
      active_base <= '0;
      accumulator <= '0;
      minus_seen <= 1'b0;
      digit_seen <= 1'b0;
      position <= '0;
      res_valid <= 1'b0;
    end else begin
      if (item_valid && item_take) begin
        phase <= phase_next;
        active_base <= active_base_next;
        accumulator <= accumulator_next;
        minus_seen <= minus_seen_next;
        digit_seen <= digit_seen_next;
        position <= position_next;
      end
      if (item_valid && item_take && emit) begin
        res_valid <= 1'b1;
        result <= result_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/integer_text_parser.sv -----
// ----------------------------------------------------------------------------
// Integer text parser
// Streams characters in and returns one parsed integer per string.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// s_*      in   tdata: ch[7:0], base[13:8], zero pad[15:14]; tuser: start_req
// m_*      out  tdata: value[63:0], negative[64], any_digits[65],
//               end_offset[78:66], zero pad[79]
//
// One character request is taken per clock cycle; the rate is set by the
// single 64 by 6 bit multiply-add of the accumulator in the parse stage.
// The ending character passes the input register, then the result register.
// Reset is synchronous and returns the parser to waiting for a start mark.
// While a result waits on m_tready, one further request may enter the input
// register; after that s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // ch[7:0], base[13:8], pad[15:14]
  input  logic        s_tuser,   // start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // value, negative, any_digits, end_offset, pad
);
  import itp_pkg::*;

  itp_item_t   in_item;
  itp_item_t   item;
  logic        item_valid;
  logic        item_take;
  itp_result_t result;

  // Unpack the request; the top pad bits of tdata carry nothing.
  assign in_item.ch = s_tdata[7:0];
  assign in_item.base = s_tdata[13:8];
  assign in_item.start_req = s_tuser;

  // The input register parts the upstream handshake from the parse stage.
  itp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .item_valid(item_valid),
    .item_take (item_take),
    .item      (item)
  );

  // The core keeps the parse state and owns the result register.
  itp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_take (item_take),
    .item      (item),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {1'b0, result};

endmodule

// ----- rtl/itp_checker.sv -----
// ----------------------------------------------------------------------------
// Integer text parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_text_parser_defines.svh"

module itp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);
  import itp_pkg::*;

  `ITP_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid)
  `ITP_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ITP_ASSERT_SAME(a_no_digit, clk, rst, m_tvalid && !m_tdata[65], m_tdata[78:66] == 13'd0 && m_tdata[63:0] == 64'd0)
  `ITP_ASSERT_SAME(a_offset_cap, clk, rst, m_tvalid, m_tdata[78:66] <= OFF_W'(MAX_CHARS))

endmodule

bind integer_text_parser itp_checker u_itp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
